/* design/src_pkg.sv */
// shared types and constants for the shot recall controller
package src_pkg;

  typedef enum logic [3:0] {
    CMD_SELECT    = 4'd0,
    CMD_DESELECT  = 4'd1,
    CMD_GRAB      = 4'd2,
    CMD_FORCE_DES = 4'd3,
    CMD_STORE     = 4'd4,
    CMD_STORE_NXT = 4'd5,
    CMD_SET_TIME  = 4'd6,
    CMD_FADE      = 4'd7,
    CMD_CUT       = 4'd8,
    CMD_STOP      = 4'd9,
    CMD_JOYSTICK  = 4'd10,
    CMD_TICK      = 4'd11
  } cmd_t;

  localparam logic [1:0] EN_NONE    = 2'd0;
  localparam logic [1:0] EN_ENABLE  = 2'd1;
  localparam logic [1:0] EN_DISABLE = 2'd2;

  localparam logic [1:0] MOT_NONE  = 2'd0;
  localparam logic [1:0] MOT_START = 2'd1;
  localparam logic [1:0] MOT_HALT  = 2'd2;
  localparam logic [1:0] MOT_JOY   = 2'd3;

  localparam logic [1:0] REG_GRACE = 2'd0;
  localparam logic [1:0] REG_ACK   = 2'd1;
  localparam logic [1:0] REG_JOY   = 2'd2;
  localparam logic [1:0] REG_FMIN  = 2'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_EXEC,
    ST_OUT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic rd;
    logic exec;
  } src_cmd_t;

  // datapath to controller (reserved status)
  typedef struct packed {
    logic busy;
  } src_stat_t;

endpackage

/* design/src_ctrl.sv */
// control state machine: capture, table read, execute, output hold
module src_ctrl
  import src_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_fire,
  input  logic      out_fire,
  input  src_stat_t stat,
  output logic      in_ready,
  output logic      out_valid,
  output src_cmd_t  cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    in_ready = 1'b0;
    out_valid = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = !stat.busy && !rst;
        if (in_fire) begin
          cmd.capture = 1'b1;
          state_next = ST_READ;
        end
      end
      ST_READ: begin
        cmd.rd = 1'b1;
        state_next = ST_EXEC;
      end
      ST_EXEC: begin
        cmd.exec = 1'b1;
        state_next = ST_OUT;
      end
      ST_OUT: begin
        out_valid = 1'b1;
        if (out_fire) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  assert property (@(posedge clk) disable iff (rst) in_fire |=> state == ST_READ)
    else $error("capture did not start a read");
  assert property (@(posedge clk) disable iff (rst) cmd.exec |=> out_valid)
    else $error("execute not followed by output");
  assert property (@(posedge clk) disable iff (rst) !(in_ready && out_valid))
    else $error("input and output open together");

endmodule

/* design/src_datapath.sv */
// datapath: ownership, shot table memory, recall timing and motor watchdogs
module src_datapath
  import src_pkg::*;
#(
  parameter int SHOT_SLOTS = 128
) (
  input  logic         clk,
  input  logic         rst,
  input  src_cmd_t     cmd,
  output src_stat_t    stat,
  input  logic [120:0] in_data,
  input  logic [15:0]  grace_ms,
  input  logic [15:0]  ack_ms,
  input  logic [15:0]  joy_ms,
  input  logic [7:0]   fade_min,
  output logic [103:0] out_data
);

  localparam int AW = (SHOT_SLOTS > 1) ? $clog2(SHOT_SLOTS) : 1;

  // captured item
  logic [120:0] item;
  logic [3:0]   c_cmd;
  logic [15:0]  c_id;
  logic [7:0]   c_shot;
  logic [15:0]  c_tin;
  logic [7:0]   c_pan;
  logic [31:0]  c_pos;
  logic         c_homed, c_rej, c_start, c_mmov, c_mtgt;
  logic [31:0]  c_now;

  assign c_cmd   = item[3:0];
  assign c_id    = item[19:4];
  assign c_shot  = item[27:20];
  assign c_tin   = item[43:28];
  assign c_pan   = item[51:44];
  assign c_pos   = item[83:52];
  assign c_homed = item[84];
  assign c_rej   = item[85];
  assign c_start = item[86];
  assign c_mmov  = item[87];
  assign c_mtgt  = item[88];
  assign c_now   = item[120:89];

  // state
  logic        owned;
  logic [15:0] owner;
  logic [7:0]  arrived_shot, pending_shot;
  logic [15:0] default_tenths;
  logic        moving_flag, on_shot_flag, ack_seen, ack_warned, joystick_active;
  logic [31:0] move_start_ms, last_joystick_ms;
  logic [SHOT_SLOTS-1:0] valid;

  // shot table memory: position and fade time
  logic [47:0] mem [SHOT_SLOTS];
  logic [47:0] rd_data;
  logic        rd_valid;
  logic [AW-1:0] rd_addr, wr_addr;
  logic        wr_en;
  logic [47:0] wr_data;

  // address used by the current item: pending shot on tick, else shot number
  logic [7:0] look_shot;
  logic       look_in;
  assign look_shot = (c_cmd == CMD_TICK) ? pending_shot : c_shot;
  assign look_in = (look_shot >= 8'd1) && ({24'd0, look_shot} <= SHOT_SLOTS);
  logic [7:0] look_m1;
  assign look_m1 = look_shot - 8'd1;
  assign rd_addr = look_m1[AW-1:0];

  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      rd_data <= mem[rd_addr];
      rd_valid <= look_in && valid[rd_addr];
    end
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item <= in_data;
    end
  end

  assign stat.busy = 1'b0;

  // execute logic
  logic        acc;
  logic [1:0]  en, mot;
  logic [7:0]  joy;
  logic [31:0] tgt;
  logic [15:0] dur;
  logic        dur_set, missed;
  logic        owned_n;
  logic [15:0] owner_n, default_n;
  logic [7:0]  cur_n, pend_n;
  logic        mov_n, ons_n, acks_n, ackw_n, joya_n;
  logic [31:0] mstart_n, ljoy_n;
  logic        vset;
  logic [15:0] t;
  logic [15:0] fmin16;
  logic [31:0] since_move, since_joy;
  logic [7:0]  nxt;
  logic        shot_ok;

  assign fmin16 = {8'd0, fade_min};
  assign since_move = c_now - move_start_ms;
  assign since_joy = c_now - last_joystick_ms;
  assign shot_ok = (c_shot >= 8'd1) && ({24'd0, c_shot} <= SHOT_SLOTS);
  assign nxt = (arrived_shot > 8'd0 && {24'd0, arrived_shot} < SHOT_SLOTS)
               ? arrived_shot + 8'd1 : 8'd1;

  always_comb begin
    acc = 1'b0; en = EN_NONE; mot = MOT_NONE; joy = '0; tgt = '0; dur = '0;
    dur_set = 1'b0; missed = 1'b0;
    owned_n = owned; owner_n = owner; default_n = default_tenths;
    cur_n = arrived_shot; pend_n = pending_shot; mov_n = moving_flag;
    ons_n = on_shot_flag; acks_n = ack_seen; ackw_n = ack_warned;
    joya_n = joystick_active; mstart_n = move_start_ms; ljoy_n = last_joystick_ms;
    wr_en = 1'b0; wr_addr = '0; wr_data = {c_pos, default_tenths}; vset = 1'b0;
    t = '0;
    case (c_cmd)
      CMD_SELECT: begin
        if (!(owned && owner != c_id)) begin
          owned_n = 1'b1; owner_n = c_id; en = EN_ENABLE; acc = 1'b1;
        end
      end
      CMD_DESELECT: begin
        if (owned && owner == c_id) begin
          owned_n = 1'b0; owner_n = '0; acc = 1'b1;
        end
      end
      CMD_GRAB: begin
        owned_n = 1'b1; owner_n = c_id; en = EN_ENABLE; acc = 1'b1;
      end
      CMD_FORCE_DES: begin
        if (owned && owner == c_id) begin
          owned_n = 1'b0; owner_n = '0; en = EN_DISABLE; acc = 1'b1;
        end
      end
      CMD_STORE: begin
        if (shot_ok) begin
          wr_addr = rd_addr; vset = 1'b1; cur_n = c_shot; acc = 1'b1;
        end
      end
      CMD_STORE_NXT: begin
        wr_addr = AW'(nxt - 8'd1); vset = 1'b1; cur_n = nxt; acc = 1'b1;
      end
      CMD_SET_TIME: begin
        default_n = c_tin; acc = 1'b1;
      end
      CMD_FADE, CMD_CUT: begin
        if (rd_valid && c_homed && !c_rej) begin
          if (c_cmd == CMD_CUT) begin
            t = '0;
          end else begin
            if (default_tenths != 16'd0) t = default_tenths;
            else if (rd_data[15:0] != 16'd0) t = rd_data[15:0];
            else t = fmin16;
            if (t < fmin16) t = fmin16;
          end
          mot = MOT_START; tgt = rd_data[47:16]; dur = t; dur_set = 1'b1;
          if (c_start) begin
            acc = 1'b1; pend_n = c_shot; mov_n = 1'b1; ons_n = 1'b0;
            default_n = t; mstart_n = c_now; acks_n = 1'b0; ackw_n = 1'b0;
          end
        end
      end
      CMD_STOP: begin
        mot = MOT_HALT; mov_n = 1'b0; pend_n = '0; acc = 1'b1;
      end
      CMD_JOYSTICK: begin
        if (!c_rej) begin
          ljoy_n = c_now; joya_n = 1'b1; mot = MOT_JOY; joy = c_pan; acc = 1'b1;
        end
      end
      CMD_TICK: begin
        if (joystick_active && since_joy > {16'd0, joy_ms}) begin
          mot = MOT_JOY; joya_n = 1'b0;
        end
        if (rd_valid) begin
          if (c_mmov) acks_n = 1'b1;
          if (!acks_n && !ack_warned && since_move > {16'd0, ack_ms}) begin
            missed = 1'b1; ackw_n = 1'b1;
          end
          if (c_mtgt && !c_mmov && !(since_move < {16'd0, grace_ms})) begin
            mov_n = 1'b0; ons_n = 1'b1; cur_n = pending_shot; pend_n = '0;
            default_n = '0;
          end else begin
            mov_n = 1'b1; ons_n = 1'b0;
          end
        end else begin
          mov_n = c_mmov;
        end
      end
      default: ;
    endcase
    wr_en = vset & cmd.exec;
    if (!dur_set) dur = default_n;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      owned <= 1'b0; owner <= '0; arrived_shot <= '0; pending_shot <= '0;
      default_tenths <= '0; moving_flag <= 1'b0; on_shot_flag <= 1'b0;
      move_start_ms <= '0; ack_seen <= 1'b0; ack_warned <= 1'b0;
      last_joystick_ms <= '0; joystick_active <= 1'b0; valid <= '0;
    end else if (cmd.exec) begin
      owned <= owned_n; owner <= owner_n; arrived_shot <= cur_n;
      pending_shot <= pend_n; default_tenths <= default_n; moving_flag <= mov_n;
      on_shot_flag <= ons_n; move_start_ms <= mstart_n; ack_seen <= acks_n;
      ack_warned <= ackw_n; last_joystick_ms <= ljoy_n; joystick_active <= joya_n;
      if (vset) valid[wr_addr] <= 1'b1;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      out_data <= {7'd0, ons_n, mov_n, pend_n, cur_n, owner_n, owned_n, missed,
                   dur, tgt, joy, mot, en, acc};
    end
  end

  assert property (@(posedge clk) disable iff (rst) cmd.exec |-> !cmd.rd)
    else $error("read and execute overlap");
  assert property (@(posedge clk) disable iff (rst) cmd.exec && vset |=> owned == $past(owned_n))
    else $error("state not committed on store");
  assert property (@(posedge clk) disable iff (rst) $past(cmd.exec) && !owned |-> owner == 16'd0)
    else $error("owner set while unowned");

endmodule

/* design/shot_recall_controller_top.sv */
// top level: stream ports, configuration registers, controller and datapath
// channel | dir | handshake                | payload
// s_axis  | in  | s_axis_tvalid/tready     | s_axis_tdata, 128 bits
// m_axis  | out | m_axis_tvalid/tready     | m_axis_tdata, 104 bits
// apb     | in  | psel/penable/pwrite      | paddr, pwdata, prdata
// one item passes through capture, table read, execute and hold, plus output wait
// the shot table memory read port sets the read-then-execute sequence
// the next item is taken only after the result transfer completes
// reset clears all control state and every table valid bit
module shot_recall_controller_top
  import src_pkg::*;
#(
  parameter int SHOT_SLOTS = 128
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // command, controller_id, shot_number, time_tenths_in, pan_deflection,
  // axis_position, axis_homed, begin_rejected, start_accepted,
  // motor_busy, motor_settled, now_ms, 7 pad bits
  input  logic [127:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // accepted, enable_request, motion_request, joystick_demand, move_target,
  // duration_tenths, missed_move, owner_valid, owner_id, arrived_shot,
  // next_shot_out, motion_status, 7 pad bits
  output logic [103:0] m_axis_tdata,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [3:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  logic [15:0] grace_ms, ack_ms, joy_ms;
  logic [7:0]  fade_min;
  logic [1:0]  ridx;
  logic        wr;
  src_cmd_t    cmd;
  src_stat_t   stat;

  assign pready = 1'b1;
  assign ridx = paddr[3:2];
  assign wr = psel && penable && pwrite && (paddr[1:0] == 2'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      grace_ms <= 16'd100; ack_ms <= 16'd500; joy_ms <= 16'd500; fade_min <= 8'd1;
    end else if (wr) begin
      case (ridx)
        REG_GRACE: grace_ms <= pwdata[15:0];
        REG_ACK:   ack_ms <= pwdata[15:0];
        REG_JOY:   joy_ms <= pwdata[15:0];
        REG_FMIN:  fade_min <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (ridx)
      REG_GRACE: prdata = {16'd0, grace_ms};
      REG_ACK:   prdata = {16'd0, ack_ms};
      REG_JOY:   prdata = {16'd0, joy_ms};
      REG_FMIN:  prdata = {24'd0, fade_min};
      default:   prdata = '0;
    endcase
  end

  src_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_fire(s_axis_tvalid && s_axis_tready),
    .out_fire(m_axis_tvalid && m_axis_tready),
    .stat(stat), .in_ready(s_axis_tready), .out_valid(m_axis_tvalid), .cmd(cmd)
  );

  src_datapath #(.SHOT_SLOTS(SHOT_SLOTS)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .stat(stat),
    .in_data(s_axis_tdata[120:0]),
    .grace_ms(grace_ms), .ack_ms(ack_ms), .joy_ms(joy_ms), .fade_min(fade_min),
    .out_data(m_axis_tdata)
  );

endmodule

/* sim/testbench.sv */
// self-checking testbench for the shot recall controller: directed table, then random traffic
`timescale 1ns / 100ps

module testbench;
  import src_pkg::*;

  localparam int NUM_SLOTS = 128;
  localparam int RUN_LIMIT = 600000;
  localparam int PHASE_ITEMS = 270;

  // one command transfer, the command field in the lowest bits
  typedef struct packed {
    logic [31:0]       now_ms;
    logic              settled;
    logic              moving;
    logic              started;
    logic              rejected;
    logic              homed;
    logic [31:0]       position;
    logic signed [7:0] pan;
    logic [15:0]       tenths;
    logic [7:0]        shot;
    logic [15:0]       ctrl_id;
    logic [3:0]        cmd;
  } cmd_item_t;

  // one status transfer
  typedef struct packed {
    logic [1:0]        status;
    logic [7:0]        next_shot;
    logic [7:0]        cur_shot;
    logic [15:0]       owner_id;
    logic              owner_valid;
    logic              missed;
    logic [15:0]       duration;
    logic [31:0]       target;
    logic signed [7:0] joy;
    logic [1:0]        motion;
    logic [1:0]        enable;
    logic              accepted;
  } status_t;

  typedef struct {
    cmd_item_t item;
    bit        typed;
    status_t   want;
  } row_t;

  logic         clk = 0;
  logic         rst = 1;
  logic         s_axis_tvalid = 0;
  logic         s_axis_tready;
  logic [127:0] s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 0;
  logic [103:0] m_axis_tdata;
  logic         psel = 0, penable = 0, pwrite = 0;
  logic [3:0]   paddr = '0;
  logic [31:0]  pwdata = '0;
  logic [31:0]  prdata;
  logic         pready;

  // whole item as sent, kept beside the port for the monitor
  cmd_item_t    tx_item = '0;
  bit           tx_typed = 0;
  status_t      tx_want = '0;

  status_t      expected_q[$];
  int           errors = 0;
  int           sent = 0;
  int           received = 0;
  int           cycles = 0;
  bit           long_hold_done = 0;
  logic [31:0]  clock_ms = 0;

  // predictor state
  logic [15:0] grace_ms, ack_ms, joy_ms;
  logic [7:0]  fade_floor;
  bit          slot_valid[NUM_SLOTS];
  logic [31:0] slot_pos[NUM_SLOTS];
  logic [15:0] slot_tenths[NUM_SLOTS];
  bit          p_owned;
  logic [15:0] p_owner;
  logic [7:0]  p_current, p_pending;
  logic [15:0] p_default;
  bit          p_moving, p_on_shot, p_ack_seen, p_ack_warned, p_joy_active;
  logic [31:0] p_move_start, p_last_joy;

  shot_recall_controller_top DUT (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #5 clk = ~clk;

  function automatic bit slot_ok(logic [7:0] n);
    return n >= 1 && n <= NUM_SLOTS;
  endfunction

  function automatic bit pending_live();
    return slot_ok(p_pending) && slot_valid[p_pending - 1];
  endfunction

  function automatic void reset_shot_state();
    grace_ms = 100; ack_ms = 500; joy_ms = 500; fade_floor = 1;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      slot_valid[i] = 0; slot_pos[i] = 0; slot_tenths[i] = 0;
    end
    p_owned = 0; p_owner = 0; p_current = 0; p_pending = 0; p_default = 0;
    p_moving = 0; p_on_shot = 0; p_move_start = 0; p_ack_seen = 0;
    p_ack_warned = 0; p_last_joy = 0; p_joy_active = 0;
  endfunction

  function automatic void save_shot(logic [7:0] n, logic [31:0] pos);
    slot_valid[n - 1] = 1;
    slot_pos[n - 1] = pos;
    slot_tenths[n - 1] = p_default;
    p_current = n;
  endfunction

  // advances the controller state by one command and returns its status
  function automatic status_t run_command(cmd_item_t c);
    status_t r;
    bit dur_set;
    logic [15:0] t;
    logic [31:0] since_move;
    logic [7:0] n;
    r = '0;
    dur_set = 0;
    case (c.cmd)
      CMD_SELECT: if (!(p_owned && p_owner != c.ctrl_id)) begin
        p_owned = 1; p_owner = c.ctrl_id; r.enable = EN_ENABLE; r.accepted = 1;
      end
      CMD_DESELECT: if (p_owned && p_owner == c.ctrl_id) begin
        p_owned = 0; p_owner = 0; r.accepted = 1;
      end
      CMD_GRAB: begin
        p_owned = 1; p_owner = c.ctrl_id; r.enable = EN_ENABLE; r.accepted = 1;
      end
      CMD_FORCE_DES: if (p_owned && p_owner == c.ctrl_id) begin
        p_owned = 0; p_owner = 0; r.enable = EN_DISABLE; r.accepted = 1;
      end
      CMD_STORE: if (slot_ok(c.shot)) begin
        save_shot(c.shot, c.position);
        r.accepted = 1;
      end
      CMD_STORE_NXT: begin
        n = (p_current > 0 && p_current < NUM_SLOTS) ? p_current + 8'd1 : 8'd1;
        save_shot(n, c.position);
        r.accepted = 1;
      end
      CMD_SET_TIME: begin
        p_default = c.tenths; r.accepted = 1;
      end
      CMD_FADE, CMD_CUT:
        if (slot_ok(c.shot) && slot_valid[c.shot - 1] && c.homed && !c.rejected) begin
          if (c.cmd == CMD_CUT) t = 0;
          else begin
            if (p_default > 0) t = p_default;
            else if (slot_tenths[c.shot - 1] > 0) t = slot_tenths[c.shot - 1];
            else t = fade_floor;
            if (t < fade_floor) t = fade_floor;
          end
          r.motion = MOT_START;
          r.target = slot_pos[c.shot - 1];
          r.duration = t;
          dur_set = 1;
          if (c.started) begin
            r.accepted = 1;
            p_pending = c.shot; p_moving = 1; p_on_shot = 0; p_default = t;
            p_move_start = c.now_ms; p_ack_seen = 0; p_ack_warned = 0;
          end
        end
      CMD_STOP: begin
        r.motion = MOT_HALT; p_moving = 0; p_pending = 0; r.accepted = 1;
      end
      CMD_JOYSTICK: if (!c.rejected) begin
        p_last_joy = c.now_ms; p_joy_active = 1;
        r.motion = MOT_JOY; r.joy = c.pan; r.accepted = 1;
      end
      CMD_TICK: begin
        since_move = c.now_ms - p_move_start;
        if (p_joy_active && (c.now_ms - p_last_joy) > {16'd0, joy_ms}) begin
          r.motion = MOT_JOY; r.joy = 0; p_joy_active = 0;
        end
        if (pending_live()) begin
          if (c.moving) p_ack_seen = 1;
          if (!p_ack_seen && !p_ack_warned && since_move > {16'd0, ack_ms}) begin
            r.missed = 1; p_ack_warned = 1;
          end
        end
        if (!pending_live()) p_moving = c.moving;
        else if (c.settled && !c.moving && !(since_move < {16'd0, grace_ms})) begin
          p_moving = 0; p_on_shot = 1; p_current = p_pending;
          p_pending = 0; p_default = 0;
        end else begin
          p_moving = 1; p_on_shot = 0;
        end
      end
      default: ;
    endcase
    if (!dur_set) r.duration = p_default;
    r.owner_valid = p_owned;
    r.owner_id = p_owner;
    r.cur_shot = p_current;
    r.next_shot = p_pending;
    r.status = {p_on_shot, p_moving};
    return r;
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: mismatch on %s, expected %0h, actual %0h", $time, name, want, got);
      errors++;
    end
  endtask

  // monitor: predict on every command transfer, check every status transfer
  always @(posedge clk) begin
    status_t got, want, pred;
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) begin
        pred = run_command(tx_item);
        expected_q.push_back(tx_typed ? tx_want : pred);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata[96:0];
        received++;
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected status transfer %h", $time, got);
          errors++;
        end else begin
          want = expected_q.pop_front();
          check_field("accepted", want.accepted, got.accepted);
          check_field("enable_request", want.enable, got.enable);
          check_field("motion_request", want.motion, got.motion);
          check_field("joystick_demand", 8'(want.joy), 8'(got.joy));
          check_field("move_target", want.target, got.target);
          check_field("duration_tenths", want.duration, got.duration);
          check_field("missed_move", want.missed, got.missed);
          check_field("owner_valid", want.owner_valid, got.owner_valid);
          check_field("owner_id", want.owner_id, got.owner_id);
          check_field("arrived_shot", want.cur_shot, got.cur_shot);
          check_field("next_shot_out", want.next_shot, got.next_shot);
          check_field("motion_status", want.status, got.status);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > RUN_LIMIT) begin
      $display("timeout with %0d results outstanding", expected_q.size());
      $display("status: fail");
      $finish;
    end
  end

  // receiver: random stall patterns, plus one long hold-off
  initial begin
    int mode, len;
    @(negedge rst);
    forever begin
      if (!long_hold_done && received > 300) begin
        long_hold_done = 1;
        m_axis_tready <= 0;
        repeat (400) @(posedge clk);
      end
      mode = $urandom_range(0, 3);
      len = $urandom_range(1, 40);
      repeat (len) begin
        case (mode)
          0: m_axis_tready <= 1;
          1: m_axis_tready <= $urandom_range(0, 1);
          2: m_axis_tready <= ($urandom_range(0, 3) == 0);
          default: m_axis_tready <= ($urandom_range(0, 7) != 0);
        endcase
        @(posedge clk);
      end
    end
  end

  task automatic reg_write(logic [1:0] idx, logic [31:0] value);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 2'b00}; pwdata <= value;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    case (idx)
      REG_GRACE: grace_ms = value[15:0];
      REG_ACK:   ack_ms = value[15:0];
      REG_JOY:   joy_ms = value[15:0];
      default:   fade_floor = value[7:0];
    endcase
    psel <= 0; penable <= 0; pwrite <= 0;
    @(posedge clk);
  endtask

  // offer one command and hold it until it is taken
  task automatic send_cmd(cmd_item_t c, bit typed, status_t want);
    s_axis_tvalid <= 1;
    s_axis_tdata <= 128'(c);
    tx_item <= c;
    tx_typed <= typed;
    tx_want <= want;
    do @(posedge clk); while (!s_axis_tready);
    sent++;
  endtask

  task automatic sender_gap();
    if ($urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  task automatic drain();
    s_axis_tvalid <= 0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  function automatic cmd_item_t random_cmd();
    cmd_item_t c;
    int r;
    c = '0;
    r = $urandom_range(0, 99);
    if (r < 6) c.cmd = CMD_SELECT;
    else if (r < 10) c.cmd = CMD_DESELECT;
    else if (r < 13) c.cmd = CMD_GRAB;
    else if (r < 16) c.cmd = CMD_FORCE_DES;
    else if (r < 28) c.cmd = CMD_STORE;
    else if (r < 32) c.cmd = CMD_STORE_NXT;
    else if (r < 38) c.cmd = CMD_SET_TIME;
    else if (r < 52) c.cmd = CMD_FADE;
    else if (r < 60) c.cmd = CMD_CUT;
    else if (r < 64) c.cmd = CMD_STOP;
    else if (r < 72) c.cmd = CMD_JOYSTICK;
    else if (r < 97) c.cmd = CMD_TICK;
    else c.cmd = 4'($urandom_range(12, 15));
    c.ctrl_id = ($urandom_range(0, 3) == 0) ? 16'($urandom) :
                ($urandom_range(0, 1) ? 16'd5 : 16'd9);
    case ($urandom_range(0, 19))
      0: c.shot = 0;
      1: c.shot = 8'(NUM_SLOTS);
      2: c.shot = 8'(NUM_SLOTS + 1);
      3: c.shot = 8'($urandom);
      default: c.shot = 8'($urandom_range(1, 6));
    endcase
    case ($urandom_range(0, 9))
      0: c.tenths = 0;
      1, 2: c.tenths = 16'($urandom);
      default: c.tenths = 16'($urandom_range(0, 30));
    endcase
    c.pan = 8'($urandom);
    c.position = $urandom;
    c.homed = ($urandom_range(0, 9) != 0);
    c.rejected = ($urandom_range(0, 9) == 0);
    c.started = ($urandom_range(0, 6) != 0);
    c.moving = $urandom_range(0, 1);
    c.settled = $urandom_range(0, 1);
    if ($urandom_range(0, 49) == 0) clock_ms = $urandom;
    else clock_ms = clock_ms + $urandom_range(0, 300);
    c.now_ms = clock_ms;
    return c;
  endfunction

  row_t plan[$];

  task automatic add_row(logic [3:0] cmd, logic [15:0] id, logic [7:0] shot,
                         logic [15:0] tenths, logic [7:0] pan, logic [31:0] pos,
                         logic [4:0] flags, logic [31:0] now, bit typed, status_t want);
    row_t row;
    row.item = '0;
    row.item.cmd = cmd; row.item.ctrl_id = id; row.item.shot = shot;
    row.item.tenths = tenths; row.item.pan = pan; row.item.position = pos;
    {row.item.homed, row.item.rejected, row.item.started,
     row.item.moving, row.item.settled} = flags;
    row.item.now_ms = now;
    row.typed = typed;
    row.want = want;
    plan.push_back(row);
  endtask

  initial begin
    status_t z, w;
    cmd_item_t c;
    z = '0;
    reset_shot_state();
    repeat (3) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // flags: homed, rejected, started, moving, settled
    add_row(CMD_TICK, 0, 0, 0, 0, 0, 5'b00000, 0, 1, z);
    add_row(4'd13, 16'hFFFF, 8'hFF, 16'hFFFF, 8'hFF, '1, 5'b11111, '1, 1, z);
    add_row(CMD_FADE, 1, 1, 0, 0, 0, 5'b10100, 10, 1, z);
    w = z; w.accepted = 1; w.enable = EN_ENABLE; w.owner_valid = 1; w.owner_id = 16'hFFFF;
    add_row(CMD_GRAB, 16'hFFFF, 0, 0, 0, 0, 5'b0, 20, 1, w);
    w.accepted = 0; w.enable = EN_NONE;
    add_row(CMD_SELECT, 0, 0, 0, 0, 0, 5'b0, 30, 1, w);
    add_row(CMD_FORCE_DES, 0, 0, 0, 0, 0, 5'b0, 40, 1, w);
    w = z; w.accepted = 1; w.enable = EN_DISABLE;
    add_row(CMD_FORCE_DES, 16'hFFFF, 0, 0, 0, 0, 5'b0, 50, 1, w);
    add_row(CMD_SELECT, 0, 0, 0, 0, 0, 5'b0, 60, 0, z);
    add_row(CMD_DESELECT, 0, 0, 0, 0, 0, 5'b0, 70, 0, z);
    add_row(CMD_STORE, 1, 0, 0, 0, 32'h1234, 5'b0, 80, 0, z);
    add_row(CMD_STORE, 1, 8'(NUM_SLOTS), 0, 0, 32'h7FFFFFFF, 5'b0, 90, 0, z);
    add_row(CMD_STORE_NXT, 1, 0, 0, 0, 32'h80000000, 5'b0, 95, 0, z);
    add_row(CMD_STORE, 1, 8'hFF, 0, 0, 32'h5, 5'b0, 99, 0, z);
    add_row(CMD_STORE, 1, 8'(NUM_SLOTS - 1), 0, 0, 32'h55, 5'b0, 99, 0, z);
    add_row(CMD_STORE_NXT, 1, 0, 0, 0, 32'hAA, 5'b0, 99, 0, z);
    add_row(CMD_SET_TIME, 1, 0, 16'hFFFF, 0, 0, 5'b0, 100, 0, z);
    add_row(CMD_FADE, 1, 8'(NUM_SLOTS), 0, 0, 0, 5'b10100, 1000, 0, z);
    add_row(CMD_TICK, 1, 0, 0, 0, 0, 5'b00010, 1050, 0, z);
    add_row(CMD_TICK, 1, 0, 0, 0, 0, 5'b00001, 1200, 0, z);
    add_row(CMD_FADE, 1, 1, 0, 0, 0, 5'b00100, 1300, 0, z);
    add_row(CMD_FADE, 1, 1, 0, 0, 0, 5'b11100, 1400, 0, z);
    add_row(CMD_FADE, 1, 1, 0, 0, 0, 5'b10000, 1500, 0, z);
    add_row(CMD_CUT, 1, 1, 0, 0, 0, 5'b10100, 5000, 0, z);
    add_row(CMD_TICK, 1, 0, 0, 0, 0, 5'b00000, 5600, 0, z);
    add_row(CMD_STOP, 1, 0, 0, 0, 0, 5'b0, 5700, 0, z);
    add_row(CMD_JOYSTICK, 1, 0, 0, 8'h80, 0, 5'b0, 6000, 0, z);
    add_row(CMD_TICK, 1, 0, 0, 0, 0, 5'b0, 6600, 0, z);

    foreach (plan[i]) begin
      send_cmd(plan[i].item, plan[i].typed, plan[i].want);
      sender_gap();
    end
    clock_ms = 7000;
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          reg_write(REG_GRACE, 0); reg_write(REG_ACK, 0);
          reg_write(REG_JOY, 0); reg_write(REG_FMIN, 0);
        end
        1: begin
          reg_write(REG_GRACE, 16'hFFFF); reg_write(REG_ACK, 16'hFFFF);
          reg_write(REG_JOY, 16'hFFFF); reg_write(REG_FMIN, 8'hFF);
        end
        default: begin
          reg_write(REG_GRACE, $urandom_range(0, 400));
          reg_write(REG_ACK, $urandom_range(0, 800));
          reg_write(REG_JOY, $urandom_range(0, 800));
          reg_write(REG_FMIN, $urandom_range(0, 40));
        end
      endcase
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        c = random_cmd();
        send_cmd(c, 0, z);
        // bursts of back-to-back items with occasional gaps
        sender_gap();
      end
      drain();
    end
    while (expected_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("covered %0d commands and %0d results from the directed table and random traffic",
             sent, received);
    $display("under four register settings, including all-zero and all-max thresholds");
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d mismatches", errors);
      $display("status: fail");
    end
    $finish;
  end

endmodule
